// ----- sv/squared_biquad_envelope_follower_assert.svh -----
// assertion macros for the squared biquad envelope follower
`ifndef SQUARED_BIQUAD_ENVELOPE_FOLLOWER_ASSERT_SVH
`define SQUARED_BIQUAD_ENVELOPE_FOLLOWER_ASSERT_SVH

`ifndef SYNTH

`define SBEF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sbef assertion failed");

`define SBEF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sbef assertion failed");

`else

`define SBEF_ASSERT_NOW(label, clk, rst_n, ante, cons)

`define SBEF_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- sv/sbef_pkg.sv -----
// shared types and constants of the squared biquad envelope follower
package sbef_pkg;

  localparam int COEF_W    = 24;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_B0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_B1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_A1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_A2 = 3'd4;

  localparam logic signed [COEF_W-1:0] B0_RST = 24'sd53;
  localparam logic signed [COEF_W-1:0] B1_RST = 24'sd106;
  localparam logic signed [COEF_W-1:0] B2_RST = 24'sd53;
  localparam logic signed [COEF_W-1:0] A1_RST = -24'sd2082084;
  localparam logic signed [COEF_W-1:0] A2_RST = 24'sd1033738;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_B0,
    ST_B1,
    ST_B2,
    ST_A1,
    ST_A2,
    ST_ACC,
    ST_RND,
    ST_SAT
  } seq_state_t;

  typedef struct packed {
    logic load;
    logic add;
    logic rnd;
  } acc_ctrl_t;

endpackage

// ----- sv/sbef_if.sv -----
// valid/ready channel interfaces for samples and envelope results
interface sbef_in_if #(
  parameter int W = 16
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface sbef_out_if #(
  parameter int W = 16
);
  logic              valid;
  logic              ready;
  logic signed [W:0] envelope;
  logic              saturated;

  modport source (output valid, output envelope, output saturated, input ready);
  modport sink   (input valid, input envelope, input saturated, output ready);
endinterface

// ----- sv/sbef_mul.sv -----
// shared signed multiplier with registered product
module sbef_mul #(
  parameter int BW = 18
) (
  input  logic                                  clk,
  input  logic signed [sbef_pkg::COEF_W-1:0]    mul_a,
  input  logic signed [BW-1:0]                  mul_b,
  output logic signed [sbef_pkg::COEF_W+BW-1:0] prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

endmodule

// ----- sv/sbef_acc.sv -----
// tap accumulator, round toward zero and saturation
module sbef_acc #(
  parameter int PW = 42,
  parameter int SB = 16,
  parameter int F  = 20
) (
  input  logic                    clk,
  input  sbef_pkg::acc_ctrl_t     ctrl,
  input  logic signed [PW-1:0]    prod,
  output logic signed [SB:0]      y_sat,
  output logic                    sat
);

  localparam int AW = PW + 3;
  localparam int YW = AW - F;
  localparam logic [AW-1:0] RND_BIAS = {{(AW-F){1'b0}}, {F{1'b1}}};
  localparam logic [SB:0]   SAT_HI   = {1'b0, {SB{1'b1}}};
  localparam logic [SB:0]   SAT_LO   = {1'b1, {SB{1'b0}}};

  logic signed [AW-1:0] acc_r;
  logic signed [AW-1:0] acc_nxt;
  logic signed [AW-1:0] acc_bias;
  logic signed [YW-1:0] y_r;
  logic signed [YW-1:0] y_nxt;
  logic [YW-SB-1:0]     top_bits;
  logic                 fits;

  always_comb begin
    acc_nxt = acc_r;
    if (ctrl.load) begin
      acc_nxt = AW'(prod);
    end else if (ctrl.add) begin
      acc_nxt = acc_r + AW'(prod);
    end
  end

  // bias negative sums so the arithmetic shift truncates toward zero
  always_comb begin
    acc_bias = acc_r + (acc_r[AW-1] ? RND_BIAS : '0);
    y_nxt    = y_r;
    if (ctrl.rnd) begin
      y_nxt = YW'(acc_bias >>> F);
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    y_r   <= y_nxt;
  end

  assign top_bits = y_r[YW-1:SB];
  assign fits     = (&top_bits) | (~|top_bits);
  assign sat      = ~fits;
  assign y_sat    = fits ? y_r[SB:0] : (y_r[YW-1] ? SAT_LO : SAT_HI);

endmodule

// ----- sv/squared_biquad_envelope_follower.sv -----
// squared biquad envelope follower: sequencer, state and coefficient registers
// each sample runs the single shared multiplier (square plus five taps), then
//   rounding and saturation steps; the envelope registers after saturation,
//   which waits while a result is untaken; no new sample is taken until idle
// reset: coefficients return to their defaults, filter history clears to zero,
//   no result pending
`include "squared_biquad_envelope_follower_assert.svh"

module squared_biquad_envelope_follower #(
  parameter int SAMPLE_BITS    = 16,
  parameter int COEF_FRAC_BITS = 20
) (
  input  logic                               clk,
  input  logic                               rst_n,
  sbef_in_if.sink                            in_ch,
  sbef_out_if.source                         out_ch,
  input  logic                               cfg_we,
  input  logic [sbef_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sbef_pkg::COEF_W-1:0]        cfg_wdata
);

  localparam int CW = sbef_pkg::COEF_W;
  localparam int SB = SAMPLE_BITS;
  localparam int BW = SB + 2;
  localparam int PW = CW + BW;
  localparam int OW = SB + 1;
  localparam logic [OW-1:0] SAT_HI = {1'b0, {SB{1'b1}}};
  localparam logic [OW-1:0] SAT_LO = {1'b1, {SB{1'b0}}};

  sbef_pkg::seq_state_t state_r;
  sbef_pkg::seq_state_t state_nxt;
  sbef_pkg::acc_ctrl_t  ctrl;

  logic signed [CW-1:0] coef_b0_r;
  logic signed [CW-1:0] coef_b1_r;
  logic signed [CW-1:0] coef_b2_r;
  logic signed [CW-1:0] coef_a1_r;
  logic signed [CW-1:0] coef_a2_r;

  logic [SB-1:0]        sq_r;
  logic [SB-1:0]        prev_sq_r;
  logic [SB-1:0]        prev2_sq_r;
  logic signed [OW-1:0] prev_out_r;
  logic signed [OW-1:0] prev2_out_r;

  logic signed [OW-1:0] out_env_r;
  logic                 out_sat_r;
  logic                 out_valid_r;
  logic                 out_free;
  logic                 in_fire;

  logic signed [CW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;
  logic signed [PW-1:0] prod_r;
  logic [SB-1:0]        sq_slice;
  logic signed [OW-1:0] y_sat;
  logic                 sat;

  assign sq_slice  = prod_r[2*SB-2 -: SB];
  assign out_free  = !out_valid_r || out_ch.ready;
  assign in_fire   = in_ch.valid && in_ch.ready;

  assign in_ch.ready      = (state_r == sbef_pkg::ST_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.envelope  = out_env_r;
  assign out_ch.saturated = out_sat_r;

  sbef_mul #(
    .BW (BW)
  ) u_mul (
    .clk    (clk),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .prod_r (prod_r)
  );

  sbef_acc #(
    .PW (PW),
    .SB (SB),
    .F  (COEF_FRAC_BITS)
  ) u_acc (
    .clk   (clk),
    .ctrl  (ctrl),
    .prod  (prod_r),
    .y_sat (y_sat),
    .sat   (sat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sbef_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // operand select per step; feedback taps are negated on the way in
  always_comb begin
    state_nxt = state_r;
    ctrl      = '0;
    mul_a     = '0;
    mul_b     = '0;
    case (state_r)
      sbef_pkg::ST_IDLE: begin
        mul_a = CW'(in_ch.sample);
        mul_b = BW'(in_ch.sample);
        if (in_ch.valid) begin
          state_nxt = sbef_pkg::ST_B0;
        end
      end
      sbef_pkg::ST_B0: begin
        mul_a     = coef_b0_r;
        mul_b     = BW'({1'b0, sq_slice});
        state_nxt = sbef_pkg::ST_B1;
      end
      sbef_pkg::ST_B1: begin
        mul_a     = coef_b1_r;
        mul_b     = BW'({1'b0, prev_sq_r});
        ctrl.load = 1'b1;
        state_nxt = sbef_pkg::ST_B2;
      end
      sbef_pkg::ST_B2: begin
        mul_a     = coef_b2_r;
        mul_b     = BW'({1'b0, prev2_sq_r});
        ctrl.add  = 1'b1;
        state_nxt = sbef_pkg::ST_A1;
      end
      sbef_pkg::ST_A1: begin
        mul_a     = coef_a1_r;
        mul_b     = -BW'(prev_out_r);
        ctrl.add  = 1'b1;
        state_nxt = sbef_pkg::ST_A2;
      end
      sbef_pkg::ST_A2: begin
        mul_a     = coef_a2_r;
        mul_b     = -BW'(prev2_out_r);
        ctrl.add  = 1'b1;
        state_nxt = sbef_pkg::ST_ACC;
      end
      sbef_pkg::ST_ACC: begin
        ctrl.add  = 1'b1;
        state_nxt = sbef_pkg::ST_RND;
      end
      sbef_pkg::ST_RND: begin
        ctrl.rnd  = 1'b1;
        state_nxt = sbef_pkg::ST_SAT;
      end
      sbef_pkg::ST_SAT: begin
        if (out_free) begin
          state_nxt = sbef_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sbef_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_b0_r <= sbef_pkg::B0_RST;
      coef_b1_r <= sbef_pkg::B1_RST;
      coef_b2_r <= sbef_pkg::B2_RST;
      coef_a1_r <= sbef_pkg::A1_RST;
      coef_a2_r <= sbef_pkg::A2_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        sbef_pkg::REG_B0: coef_b0_r <= cfg_wdata;
        sbef_pkg::REG_B1: coef_b1_r <= cfg_wdata;
        sbef_pkg::REG_B2: coef_b2_r <= cfg_wdata;
        sbef_pkg::REG_A1: coef_a1_r <= cfg_wdata;
        sbef_pkg::REG_A2: coef_a2_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == sbef_pkg::ST_B0) begin
      sq_r <= sq_slice;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_sq_r   <= '0;
      prev2_sq_r  <= '0;
      prev_out_r  <= '0;
      prev2_out_r <= '0;
    end else if (state_r == sbef_pkg::ST_SAT && out_free) begin
      prev_sq_r   <= sq_r;
      prev2_sq_r  <= prev_sq_r;
      prev_out_r  <= y_sat;
      prev2_out_r <= prev_out_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == sbef_pkg::ST_SAT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == sbef_pkg::ST_SAT && out_free) begin
      out_env_r <= y_sat;
      out_sat_r <= sat;
    end
  end

  `SBEF_ASSERT_NEXT(a_accept_starts, clk, rst_n, in_fire, state_r == sbef_pkg::ST_B0 && !in_ch.ready)
  `SBEF_ASSERT_NOW(a_sat_clips, clk, rst_n, out_valid_r && out_sat_r, out_env_r == SAT_HI || out_env_r == SAT_LO)
  `SBEF_ASSERT_NEXT(a_feedback_matches, clk, rst_n, state_r == sbef_pkg::ST_SAT && out_free, out_valid_r && prev_out_r == out_env_r && state_r == sbef_pkg::ST_IDLE)

endmodule
